// ===== design/spc_pkg.sv =====
// Shared constants, codes and types for the servo PWM generator.
// Depends on nothing; every other design file imports it.
package spc_pkg;

  // Block geometry.
  localparam int NUM_GROUPS         = 4;
  localparam int CHANNELS_PER_GROUP = 4;
  localparam int NUM_CHANNELS       = 16;
  localparam int COUNTER_BITS       = 20;

  // Timing constants.
  localparam int TICK_HZ      = 1000000;
  localparam int RATE_MAX     = 10000;
  localparam int RATE_DEFAULT = 50;

  // Field and register widths.
  localparam int RATE_REGS  = 4;
  localparam int RATE_W     = 14;
  localparam int PRESENT_W  = 4;
  localparam int ENABLE_W   = 16;
  localparam int POS_W      = 16;
  localparam int READ_W     = 17;
  localparam int LEVEL_W    = 16;
  localparam int ACTION_W   = 3;
  localparam int CHAN_W     = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Derived widths.
  localparam int GROUP_W  = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
  localparam int CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int DIV_W    = $clog2(TICK_HZ + 1);
  localparam int STEP_W   = $clog2(DIV_W + 1);
  localparam int CMP_W    = (COUNTER_BITS > POS_W) ? COUNTER_BITS : POS_W;

  // Action codes of an input word.
  localparam logic [ACTION_W-1:0] ACT_TICK   = ACTION_W'(0);
  localparam logic [ACTION_W-1:0] ACT_SET    = ACTION_W'(1);
  localparam logic [ACTION_W-1:0] ACT_GET    = ACTION_W'(2);
  localparam logic [ACTION_W-1:0] ACT_ARM    = ACTION_W'(3);
  localparam logic [ACTION_W-1:0] ACT_DISARM = ACTION_W'(4);

  // Register indexes; the rate registers sit at 0 .. RATE_REGS-1.
  localparam logic [CFG_IDX_W-1:0] REG_PRESENT = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE  = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT = CFG_IDX_W'(6);

  typedef logic [COUNTER_BITS-1:0] counter_t;
  typedef logic [POS_W-1:0]        pos_t;

  localparam counter_t PERIOD_RESET = COUNTER_BITS'(TICK_HZ / RATE_DEFAULT);
  localparam logic [PRESENT_W-1:0] PRESENT_RESET = '1;

  // Decoded operation of one input word, valid only in the cycle it executes.
  typedef struct packed {
    logic              tick;
    logic              set;
    logic              get;
    logic              arm;
    logic              disarm;
    logic [CHAN_W-1:0] channel;
    pos_t              position;
  } spc_op_t;

  // Decoded configuration write.
  typedef struct packed {
    logic                  rate_wr;
    logic [GROUP_W-1:0]    group;
    logic                  present_wr;
    logic                  enable_wr;
    logic                  default_wr;
    logic [CFG_DATA_W-1:0] data;
  } spc_cfg_op_t;

  // One result word.
  typedef struct packed {
    logic               status;
    logic [READ_W-1:0]  read_position;
    logic [LEVEL_W-1:0] pwm_levels;
    logic               is_armed;
  } spc_res_t;

endpackage

// ===== design/spc_if.sv =====
// Valid/ready channel interfaces for input words, result words and config writes.
// Depends on spc_pkg for the field widths.

interface spc_item_if;
  import spc_pkg::*;
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [CHAN_W-1:0]   channel;
  logic [POS_W-1:0]    position;

  modport source (output valid, action, channel, position, input ready);
  modport sink   (input valid, action, channel, position, output ready);
endinterface

interface spc_result_if;
  import spc_pkg::*;
  logic               valid;
  logic               ready;
  logic               status;
  logic [READ_W-1:0]  read_position;
  logic [LEVEL_W-1:0] pwm_levels;
  logic               is_armed;

  modport source (output valid, status, read_position, pwm_levels, is_armed, input ready);
  modport sink   (input valid, status, read_position, pwm_levels, is_armed, output ready);
endinterface

interface spc_cfg_if;
  import spc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/servo_pwm_generator_core.sv =====
// A word passes through the input register, then the result register; throughput is
// one word per cycle while the result side is ready and the period divider is idle.
// A stalled result word holds the input stage, so input words wait with it.
// A rate write in range runs the period divider, one quotient bit per cycle;
// neither the input nor the config port accepts while the divider runs.
// Reset (rst, synchronous, active high) disarms, zeroes counters and compares, sets
// every period to 20000 ticks, marks all groups present and all channels disabled.
module servo_pwm_generator_core (
  input  logic         clk,
  input  logic         rst,
  spc_item_if.sink     item,
  spc_result_if.source result,
  spc_cfg_if.sink      cfg
);
  import spc_pkg::*;

  logic                a_valid;
  logic [ACTION_W-1:0] a_action;
  logic [CHAN_W-1:0]   a_channel;
  pos_t                a_position;
  logic                r_valid;
  spc_res_t            r_data;

  logic                advance;
  logic                cfg_fire;
  logic [RATE_W-1:0]   rate;
  logic                rate_ok;
  spc_op_t             op;
  spc_cfg_op_t         cfg_op;
  spc_res_t            res_next;
  logic                div_busy;
  logic                div_done;
  logic [DIV_W-1:0]    div_quot;
  logic [GROUP_W-1:0]  div_group;

  // Handshake: the input stage moves on whenever the result register is free or drains.
  assign advance    = a_valid && (!r_valid || result.ready);
  assign item.ready = !div_busy && (!a_valid || advance);
  assign cfg.ready  = !div_busy;
  assign cfg_fire   = cfg.valid && cfg.ready;

  // Decode the word held in the input stage.
  always_comb begin
    op.tick     = advance && (a_action == ACT_TICK);
    op.set      = advance && (a_action == ACT_SET);
    op.get      = advance && (a_action == ACT_GET);
    op.arm      = advance && (a_action == ACT_ARM);
    op.disarm   = advance && (a_action == ACT_DISARM);
    op.channel  = a_channel;
    op.position = a_position;
  end

  // Decode a config write; out-of-range rates are dropped.
  always_comb begin
    rate              = cfg.data[RATE_W-1:0];
    rate_ok           = (rate != '0) && (rate <= RATE_W'(RATE_MAX));
    cfg_op.rate_wr    = cfg_fire && (cfg.index < RATE_REGS) &&
                        (cfg.index < NUM_GROUPS) && rate_ok;
    cfg_op.group      = GROUP_W'(cfg.index);
    cfg_op.present_wr = cfg_fire && (cfg.index == REG_PRESENT);
    cfg_op.enable_wr  = cfg_fire && (cfg.index == REG_ENABLE);
    cfg_op.default_wr = cfg_fire && (cfg.index == REG_DEFAULT);
    cfg_op.data       = cfg.data;
  end

  spc_period_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cfg_op.rate_wr),
    .divisor   (rate),
    .group_in  (cfg_op.group),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (div_quot),
    .group_out (div_group)
  );

  spc_timer_core u_core (
    .clk          (clk),
    .rst          (rst),
    .op           (op),
    .cfg_op       (cfg_op),
    .period_wr    (div_done),
    .period_group (div_group),
    .period_quot  (div_quot),
    .res_next     (res_next)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (item.ready) begin
      a_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      a_action   <= item.action;
      a_channel  <= item.channel;
      a_position <= item.position;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (advance) begin
      r_valid <= 1'b1;
    end else if (result.ready) begin
      r_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      r_data <= res_next;
    end
  end

  assign result.valid         = r_valid;
  assign result.status        = r_data.status;
  assign result.read_position = r_data.read_position;
  assign result.pwm_levels    = r_data.pwm_levels;
  assign result.is_armed      = r_data.is_armed;

endmodule

// ===== design/spc_period_div.sv =====
// Restoring divider that turns a group rate in Hz into its period in ticks.
// Depends on spc_pkg; produces one quotient bit per cycle.
module spc_period_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [spc_pkg::RATE_W-1:0]  divisor,
  input  logic [spc_pkg::GROUP_W-1:0] group_in,
  output logic                        busy,
  output logic                        done,
  output logic [spc_pkg::DIV_W-1:0]   quotient,
  output logic [spc_pkg::GROUP_W-1:0] group_out
);
  import spc_pkg::*;

  logic [STEP_W-1:0]  steps;
  logic [RATE_W-1:0]  rem;
  logic [RATE_W-1:0]  dvs;
  logic [DIV_W-1:0]   quo;
  logic [GROUP_W-1:0] grp;

  logic [RATE_W:0]    rem_sh;
  logic [RATE_W:0]    diff;
  logic               ge;
  logic [RATE_W-1:0]  rem_next;

  // One restoring step: bring down the next dividend bit and try a subtract.
  always_comb begin
    rem_sh   = {rem, quo[DIV_W-1]};
    diff     = rem_sh - {1'b0, dvs};
    ge       = (rem_sh >= {1'b0, dvs});
    rem_next = ge ? diff[RATE_W-1:0] : rem_sh[RATE_W-1:0];
  end

  // The dividend shifts out of quo while quotient bits shift in.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(DIV_W);
        rem   <= '0;
        quo   <= DIV_W'(TICK_HZ);
        dvs   <= divisor;
        grp   <= group_in;
      end else if (busy) begin
        quo   <= {quo[DIV_W-2:0], ge};
        rem   <= rem_next;
        steps <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient  = quo;
  assign group_out = grp;

endmodule

// ===== design/spc_timer_core.sv =====
// Group counters, compare registers, configuration state and result logic.
// Depends on spc_pkg; the top level registers the result word it computes.
module spc_timer_core (
  input  logic                        clk,
  input  logic                        rst,
  input  spc_pkg::spc_op_t            op,
  input  spc_pkg::spc_cfg_op_t        cfg_op,
  input  logic                        period_wr,
  input  logic [spc_pkg::GROUP_W-1:0] period_group,
  input  logic [spc_pkg::DIV_W-1:0]   period_quot,
  output spc_pkg::spc_res_t           res_next
);
  import spc_pkg::*;

  localparam int EXT_W = DIV_W + COUNTER_BITS;
  localparam int PX_W  = NUM_GROUPS + PRESENT_W;
  localparam int EX_W  = NUM_CHANNELS + ENABLE_W;
  localparam int LX_W  = NUM_CHANNELS + LEVEL_W;

  counter_t               counter      [NUM_GROUPS];
  counter_t               counter_next [NUM_GROUPS];
  counter_t               period       [NUM_GROUPS];
  counter_t               period_next  [NUM_GROUPS];
  pos_t                   preload      [NUM_CHANNELS];
  pos_t                   preload_next [NUM_CHANNELS];
  pos_t                   active       [NUM_CHANNELS];
  pos_t                   active_next  [NUM_CHANNELS];
  logic                   armed;
  logic                   armed_next;
  logic [PRESENT_W-1:0]   present;
  logic [PRESENT_W-1:0]   present_next;
  logic [ENABLE_W-1:0]    enable;
  logic [ENABLE_W-1:0]    enable_next;

  logic [PX_W-1:0]        present_ext;
  logic [EX_W-1:0]        enable_ext;
  logic [LX_W-1:0]        levels_ext;
  logic [NUM_GROUPS-1:0]  grp_ok;
  logic [NUM_GROUPS-1:0]  grp_run;
  logic [NUM_GROUPS-1:0]  grp_upd;
  logic [NUM_CHANNELS-1:0] ch_ok;
  logic [CH_IDX_W-1:0]    sel_idx;
  logic                   sel_ok;
  pos_t                   sel_preload;
  pos_t                   set_value;
  logic [EXT_W-1:0]       quot_ext;
  counter_t               period_value;

  // Groups beyond the present mask and channels beyond the enable mask read as absent.
  assign present_ext  = PX_W'(present);
  assign enable_ext   = EX_W'(enable);
  assign quot_ext     = EXT_W'(period_quot);
  assign period_value = quot_ext[COUNTER_BITS-1:0];

  // Per-group run and forced-update decisions.
  always_comb begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      grp_ok[g]  = present_ext[g];
      grp_run[g] = op.tick && armed && grp_ok[g];
      grp_upd[g] = grp_ok[g] && (op.arm ||
                   (cfg_op.rate_wr && (cfg_op.group == GROUP_W'(g))) ||
                   (grp_run[g] && (counter[g] >= period[g])));
    end
  end

  // Channel usability and the selected channel for set or get.
  always_comb begin
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      ch_ok[c] = (c < LEVEL_W) && grp_ok[c / CHANNELS_PER_GROUP] && enable_ext[c];
    end
    sel_idx     = op.channel[CH_IDX_W-1:0];
    sel_ok      = (op.channel < NUM_CHANNELS) && ch_ok[sel_idx];
    sel_preload = preload[sel_idx];
    set_value   = (op.position != '0) ? (op.position - POS_W'(1)) : '0;
  end

  // Next state of counters, periods and configuration.
  always_comb begin
    armed_next = armed;
    if (op.arm) begin
      armed_next = 1'b1;
    end
    if (op.disarm) begin
      armed_next = 1'b0;
    end

    for (int g = 0; g < NUM_GROUPS; g++) begin
      counter_next[g] = counter[g];
      if (grp_upd[g]) begin
        counter_next[g] = '0;
      end else if (grp_run[g]) begin
        counter_next[g] = counter[g] + COUNTER_BITS'(1);
      end
      period_next[g] = period[g];
      if (period_wr && (period_group == GROUP_W'(g))) begin
        period_next[g] = period_value;
      end
    end

    present_next = cfg_op.present_wr ? cfg_op.data[PRESENT_W-1:0] : present;
    enable_next  = cfg_op.enable_wr  ? cfg_op.data[ENABLE_W-1:0]  : enable;
  end

  // Compares: set writes preload, group update copies it to active, default sets both.
  always_comb begin
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      preload_next[c] = preload[c];
      active_next[c]  = active[c];
      if (cfg_op.default_wr) begin
        preload_next[c] = cfg_op.data[POS_W-1:0];
        active_next[c]  = cfg_op.data[POS_W-1:0];
      end else begin
        if (op.set && sel_ok && (sel_idx == CH_IDX_W'(c))) begin
          preload_next[c] = set_value;
        end
        if (grp_upd[c / CHANNELS_PER_GROUP]) begin
          active_next[c] = preload[c];
        end
      end
    end
  end

  // Result word as seen after this word's update.
  always_comb begin
    levels_ext = '0;
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      levels_ext[c] = ch_ok[c] &&
        (CMP_W'(counter_next[c / CHANNELS_PER_GROUP]) < CMP_W'(active_next[c]));
    end
    res_next.status        = (op.set || op.get) && !sel_ok;
    res_next.read_position = (op.get && sel_ok) ?
                             (READ_W'(sel_preload) + READ_W'(1)) : '0;
    res_next.pwm_levels    = levels_ext[LEVEL_W-1:0];
    res_next.is_armed      = armed_next;
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      armed   <= 1'b0;
      present <= PRESENT_RESET;
      enable  <= '0;
      for (int g = 0; g < NUM_GROUPS; g++) begin
        counter[g] <= '0;
        period[g]  <= PERIOD_RESET;
      end
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        preload[c] <= '0;
        active[c]  <= '0;
      end
    end else begin
      armed   <= armed_next;
      present <= present_next;
      enable  <= enable_next;
      for (int g = 0; g < NUM_GROUPS; g++) begin
        counter[g] <= counter_next[g];
        period[g]  <= period_next[g];
      end
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        preload[c] <= preload_next[c];
        active[c]  <= active_next[c];
      end
    end
  end

endmodule

// ===== design/spc_checker.sv =====
// Port-level checks for the servo PWM generator, bound to the top level.
// Depends on spc_pkg and the channel interfaces of servo_pwm_generator_core.
module spc_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             item_ready,
  input logic                             res_valid,
  input logic                             res_ready,
  input logic                             res_status,
  input logic [spc_pkg::READ_W-1:0]       res_read_position,
  input logic [spc_pkg::LEVEL_W-1:0]      res_pwm_levels,
  input logic                             res_is_armed,
  input logic                             cfg_valid,
  input logic                             cfg_ready,
  input logic [spc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input logic [spc_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import spc_pkg::*;

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result word valid right after reset");

  // A rejected set or get never returns a position.
  a_status_read: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_status) |-> (res_read_position == '0))
    else $error("error status with nonzero read position");

  // A stalled result word holds.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=>
      (res_valid && $stable(res_status) && $stable(res_read_position) &&
       $stable(res_pwm_levels) && $stable(res_is_armed)))
    else $error("stalled result word changed or dropped");

  // An accepted in-range rate write occupies the divider, so input stalls next cycle.
  a_rate_blocks: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready && (cfg_index < RATE_REGS) && (cfg_index < NUM_GROUPS) &&
     (cfg_data[RATE_W-1:0] != '0) &&
     (cfg_data[RATE_W-1:0] <= RATE_W'(RATE_MAX))) |=> !item_ready)
    else $error("input accepted while period divider runs");

endmodule

bind servo_pwm_generator_core spc_checker u_spc_checker (
  .clk               (clk),
  .rst               (rst),
  .item_ready        (item.ready),
  .res_valid         (result.valid),
  .res_ready         (result.ready),
  .res_status        (result.status),
  .res_read_position (result.read_position),
  .res_pwm_levels    (result.pwm_levels),
  .res_is_armed      (result.is_armed),
  .cfg_valid         (cfg.valid),
  .cfg_ready         (cfg.ready),
  .cfg_index         (cfg.index),
  .cfg_data          (cfg.data)
);
